### rtl/core/wsrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsrq_pkg
// Sizes, status, command and outcome codes and sequencer states of the work-stealing ready queues.
// ----------------------------------------------------------------------------
package wsrq_pkg;

	localparam int TASK_SLOTS  = 4096;
	localparam int MAX_QUEUES  = 64;
	localparam int DEQUE_DEPTH = 512;

	// field widths fixed by the interface
	localparam int TASK_W   = 12;
	localparam int WORKER_W = 6;
	localparam int NQ_W     = 7;
	localparam int RR_W     = 6;
	localparam int CNT_W    = 32;
	localparam int STAT_W   = 3;

	// derived widths
	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int SCAN_W = $clog2(TASK_SLOTS + 1);
	localparam int Q_W    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int PTR_W  = $clog2(DEQUE_DEPTH);
	localparam int ENT_AW = $clog2(MAX_QUEUES * DEQUE_DEPTH);

	typedef enum logic [STAT_W-1:0] {
		TS_FREE    = 3'd0,
		TS_READY   = 3'd1,
		TS_RUNNING = 3'd2,
		TS_PARKED  = 3'd3,
		TS_DONE    = 3'd5
	} tstat_t;

	typedef enum logic [1:0] {
		CMD_SPAWN    = 2'd0,
		CMD_UNPARK   = 2'd1,
		CMD_TAKE     = 2'd2,
		CMD_COMPLETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OC_YIELD = 2'd0,
		OC_PARK  = 2'd1,
		OC_EXIT  = 2'd2
	} outcome_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SP_RD,
		S_SP_CHK,
		S_FID_RD,
		S_FID_CHK,
		S_RR_MOD,
		S_PUSH,
		S_SCAN_PUSH,
		S_PARK,
		S_POP,
		S_VICTIM,
		S_STEAL,
		S_ENT,
		S_STAT,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/core/wsrq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsrq_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module wsrq_ram #(
	parameter int DEPTH  = 4096,
	parameter int DATA_W = 3
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/work_stealing_ready_queues_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// work_stealing_ready_queues_unit
// Task scheduler: slot status table plus one ring deque per worker.
// ----------------------------------------------------------------------------
// Usage
//  Input channel (in_valid / in_stall): one request per transfer - spawn,
//  unpark, take or complete. Output channel (out_valid / out_stall): exactly
//  one result per request, in order. num_queues_wr writes num_queues; write it
//  only while no request is in flight.
//  Reset: the status table is swept to free, one slot per cycle, so the block
//  holds in_stall high until the sweep is done. The deque head and tail
//  pointers are zeroed while the sweep index is below MAX_QUEUES.
//  Flow, all through the status RAM and the deque entry RAM (registered
//  read each), one request at a time. The head/tail pointer memory is read
//  ahead of use, at the next deque index, so it adds no extra state:
//   unpark / complete : read and check the slot status, plus the enqueue.
//   enqueue           : push to the chosen deque if it has room, else probe
//                       the deques from deque 0 upward, and park if all are
//                       full; round robin first takes its counter modulo the
//                       queue count by repeated subtraction.
//   spawn             : read and check slots upward from the lowest slot
//                       that may be free, plus the enqueue.
//   take              : pop entries from the own deque tail (stale ones are
//                       dropped), then from the heads of victim deques.
//  While a result waits under out_stall the next request is accepted and
//  worked on; only its own result waits for the output register to empty.
// ----------------------------------------------------------------------------
module work_stealing_ready_queues_unit
	import wsrq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                num_queues_wr,
	input  wire logic [NQ_W-1:0]     num_queues,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic [TASK_W-1:0]   fiber_id,
	input  wire logic [WORKER_W-1:0] worker,
	input  wire logic                use_round_robin,
	input  wire logic [1:0]          outcome,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [TASK_W-1:0]   task_out,
	output      logic                found,
	output      logic                stolen,
	output      logic                overflow,
	output      logic                work_pending,
	output      logic [CNT_W-1:0]    local_pop_count,
	output      logic [CNT_W-1:0]    steal_count
);

	// ring pointer helpers
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEQUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(DEQUE_DEPTH - 1) : p - 1'b1;
	endfunction

	function automatic logic [ENT_AW-1:0] ent_addr(input logic [Q_W-1:0] q,
			input logic [PTR_W-1:0] p);
		return ENT_AW'(ENT_AW'(q) * ENT_AW'(DEQUE_DEPTH)) + ENT_AW'(p);
	endfunction

	// sequencer state
	state_t state_q, state_d;

	// request registers
	cmd_t                cmd_q;
	logic [TASK_W-1:0]   fid_q;
	logic [WORKER_W-1:0] worker_q;
	logic                rr_q;
	logic [1:0]          outcome_q;

	// working registers
	logic [SLOT_W-1:0] clr_q;
	logic [SCAN_W-1:0] scan_q;
	logic [SCAN_W-1:0] hint_q;   // every slot below is neither free nor done
	logic [SLOT_W-1:0] slot_q;
	logic [Q_W-1:0]    q_q, q_d;
	logic [Q_W-1:0]    me_q;
	logic [NQ_W-1:0]   off_q;
	logic [NQ_W-1:0]   rrmod_q;
	logic              steal_mode_q;

	// architectural state held in flops
	logic [NQ_W-1:0]       nq_q;
	logic [RR_W-1:0]       rrn_q;
	logic [MAX_QUEUES-1:0] ne_q;     // deque holds entries
	logic [CNT_W-1:0]      lpop_q;
	logic [CNT_W-1:0]      steal_q;

	// deque pointer memory, read at the next deque index every cycle
	logic [PTR_W-1:0] head_mem [MAX_QUEUES];
	logic [PTR_W-1:0] tail_mem [MAX_QUEUES];
	logic [PTR_W-1:0] hp_q, tp_q;   // head and tail of deque q_q
	logic             head_we, tail_we;
	logic [Q_W-1:0]   ptr_waddr;
	logic [PTR_W-1:0] head_wdata, tail_wdata;

	// result registers
	logic [TASK_W-1:0] res_task_q;
	logic              res_found_q;
	logic              res_stolen_q;
	logic              res_ovf_q;
	logic              out_valid_q;
	logic [TASK_W-1:0] task_out_q;
	logic              found_q;
	logic              stolen_q;
	logic              ovf_q;
	logic              pend_q;
	logic [CNT_W-1:0]  lpop_out_q;
	logic [CNT_W-1:0]  steal_out_q;

	// memory ports
	logic                st_we, st_re;
	logic [SLOT_W-1:0]   st_waddr, st_raddr;
	logic [STAT_W-1:0]   st_wdata, st_rdata;
	logic                ent_we, ent_re;
	logic [ENT_AW-1:0]   ent_waddr, ent_raddr;
	logic [TASK_W-1:0]   ent_rdata;

	// derived signals
	logic [NQ_W-1:0]       n_q;
	logic                  enq_rr;
	logic [PTR_W-1:0]      h_cur, t_cur, t_nxt, t_prv, h_nxt;
	logic                  q_full, q_empty;
	logic                  in_xfer, out_xfer, done_load;
	logic                  sp_hit, ent_ok, stat_ready;
	logic [NQ_W-1:0]       vsum;
	logic [MAX_QUEUES-1:0] qmask;
	logic                  fid_ok;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign done_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// queue count: zero counts as one, clipped at the deque count
	assign n_q = (nq_q == '0) ? NQ_W'(1) :
		(nq_q > NQ_W'(MAX_QUEUES)) ? NQ_W'(MAX_QUEUES) : nq_q;

	assign enq_rr = rr_q || (NQ_W'(worker_q) >= n_q);
	assign fid_ok = (32'(fid_q) < TASK_SLOTS);

	assign h_cur   = hp_q;
	assign t_cur   = tp_q;
	assign t_nxt   = ptr_inc(t_cur);
	assign t_prv   = ptr_dec(t_cur);
	assign h_nxt   = ptr_inc(h_cur);
	assign q_full  = (t_nxt == h_cur);
	assign q_empty = (h_cur == t_cur);

	assign sp_hit     = (st_rdata == TS_FREE) || (st_rdata == TS_DONE);
	assign ent_ok     = (32'(ent_rdata) < TASK_SLOTS);
	assign stat_ready = (st_rdata == TS_READY);
	assign vsum       = NQ_W'(me_q) + off_q;

	always_comb begin
		for (int i = 0; i < MAX_QUEUES; i++) begin
			qmask[i] = (NQ_W'(i) < n_q);
		end
	end

	// ---------------- memories ----------------
	wsrq_ram #(.DEPTH(TASK_SLOTS), .DATA_W(STAT_W)) u_stat_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	wsrq_ram #(.DEPTH(MAX_QUEUES * DEQUE_DEPTH), .DATA_W(TASK_W)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (TASK_W'(slot_q)),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// pointer memory: written at q_q (or the sweep index), read at q_d so
	// that hp_q / tp_q hold the pointers of q_q; same-entry writes bypass
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[ptr_waddr] <= head_wdata;
		end
		if (tail_we) begin
			tail_mem[ptr_waddr] <= tail_wdata;
		end
	end

	always_ff @(posedge clk) begin
		hp_q <= (head_we && (ptr_waddr == q_d)) ? head_wdata : head_mem[q_d];
		tp_q <= (tail_we && (ptr_waddr == q_d)) ? tail_wdata : tail_mem[q_d];
	end

	// ---------------- next deque index ----------------
	always_comb begin
		q_d = q_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					// own deque for take: deque 0 under round robin or without a valid own deque
					if (use_round_robin || (NQ_W'(worker) >= n_q)) begin
						q_d = '0;
					end else begin
						q_d = worker[Q_W-1:0];
					end
				end
			end
			S_SP_CHK: begin
				if (sp_hit) begin
					q_d = worker_q[Q_W-1:0];
				end
			end
			S_FID_CHK: begin
				q_d = worker_q[Q_W-1:0];
			end
			S_RR_MOD: begin
				if (rrmod_q < n_q) begin
					q_d = rrmod_q[Q_W-1:0];
				end
			end
			S_PUSH: begin
				if (q_full) begin
					q_d = '0;
				end
			end
			S_SCAN_PUSH: begin
				if (q_full) begin
					q_d = q_q + 1'b1;
				end
			end
			S_VICTIM: begin
				q_d = (vsum >= n_q) ? Q_W'(vsum - n_q) : Q_W'(vsum);
			end
			default: q_d = q_q;
		endcase
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == SLOT_W'(TASK_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_xfer) begin
					case (cmd_t'(cmd))
						CMD_SPAWN:  state_d = S_SP_RD;
						CMD_TAKE:   state_d = S_POP;
						default:    state_d = S_FID_RD;
					endcase
				end
			end
			S_SP_RD: begin
				state_d = (scan_q == SCAN_W'(TASK_SLOTS)) ? S_DONE : S_SP_CHK;
			end
			S_SP_CHK: begin
				if (sp_hit) begin
					state_d = enq_rr ? S_RR_MOD : S_PUSH;
				end else begin
					state_d = S_SP_RD;
				end
			end
			S_FID_RD: begin
				state_d = fid_ok ? S_FID_CHK : S_DONE;
			end
			S_FID_CHK: begin
				state_d = S_DONE;
				if ((cmd_q == CMD_UNPARK && st_rdata == TS_PARKED) ||
						(cmd_q == CMD_COMPLETE && st_rdata == TS_RUNNING &&
						outcome_q == OC_YIELD)) begin
					state_d = enq_rr ? S_RR_MOD : S_PUSH;
				end
			end
			S_RR_MOD: begin
				if (rrmod_q < n_q) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				state_d = q_full ? S_SCAN_PUSH : S_DONE;
			end
			S_SCAN_PUSH: begin
				if (!q_full) begin
					state_d = S_DONE;
				end else if (NQ_W'(q_q) + NQ_W'(1) == n_q) begin
					state_d = S_PARK;
				end
			end
			S_PARK:   state_d = S_DONE;
			S_POP:    state_d = q_empty ? S_VICTIM : S_ENT;
			S_VICTIM: state_d = (off_q >= n_q) ? S_DONE : S_STEAL;
			S_STEAL:  state_d = q_empty ? S_VICTIM : S_ENT;
			S_ENT: begin
				if (ent_ok) begin
					state_d = S_STAT;
				end else begin
					state_d = steal_mode_q ? S_STEAL : S_POP;
				end
			end
			S_STAT: begin
				if (stat_ready) begin
					state_d = S_DONE;
				end else begin
					state_d = steal_mode_q ? S_STEAL : S_POP;
				end
			end
			S_DONE: begin
				if (done_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- memory port controls ----------------
	always_comb begin
		st_we      = 1'b0;
		st_waddr   = slot_q;
		st_wdata   = TS_FREE;
		st_re      = 1'b0;
		st_raddr   = scan_q[SLOT_W-1:0];
		ent_we     = 1'b0;
		ent_waddr  = ent_addr(q_q, t_cur);
		ent_re     = 1'b0;
		ent_raddr  = ent_addr(q_q, t_prv);
		head_we    = 1'b0;
		tail_we    = 1'b0;
		ptr_waddr  = q_q;
		head_wdata = h_nxt;
		tail_wdata = t_nxt;
		case (state_q)
			S_CLEAR: begin
				st_we      = 1'b1;
				st_waddr   = clr_q;
				head_we    = (clr_q < SLOT_W'(MAX_QUEUES));
				tail_we    = (clr_q < SLOT_W'(MAX_QUEUES));
				ptr_waddr  = clr_q[Q_W-1:0];
				head_wdata = '0;
				tail_wdata = '0;
			end
			S_SP_RD: begin
				st_re = (scan_q != SCAN_W'(TASK_SLOTS));
			end
			S_SP_CHK: begin
				st_we    = sp_hit;
				st_waddr = scan_q[SLOT_W-1:0];
				st_wdata = TS_READY;
			end
			S_FID_RD: begin
				st_re    = fid_ok;
				st_raddr = fid_q[SLOT_W-1:0];
			end
			S_FID_CHK: begin
				st_waddr = fid_q[SLOT_W-1:0];
				if (cmd_q == CMD_UNPARK) begin
					st_we    = (st_rdata == TS_PARKED);
					st_wdata = TS_READY;
				end else if (st_rdata == TS_RUNNING) begin
					case (outcome_t'(outcome_q))
						OC_YIELD: begin
							st_we    = 1'b1;
							st_wdata = TS_READY;
						end
						OC_PARK: begin
							st_we    = 1'b1;
							st_wdata = TS_PARKED;
						end
						OC_EXIT: begin
							st_we    = 1'b1;
							st_wdata = TS_DONE;
						end
						default: st_we = 1'b0;
					endcase
				end
			end
			S_PUSH, S_SCAN_PUSH: begin
				ent_we  = !q_full;
				tail_we = !q_full;
			end
			S_PARK: begin
				st_we    = 1'b1;
				st_wdata = TS_PARKED;
			end
			S_POP: begin
				ent_re     = !q_empty;
				tail_we    = !q_empty;
				tail_wdata = t_prv;
			end
			S_STEAL: begin
				ent_re    = !q_empty;
				ent_raddr = ent_addr(q_q, h_cur);
				head_we   = !q_empty;
			end
			S_ENT: begin
				st_re    = ent_ok;
				st_raddr = ent_rdata[SLOT_W-1:0];
			end
			S_STAT: begin
				st_we    = stat_ready;
				st_wdata = TS_RUNNING;
			end
			default: st_we = 1'b0;
		endcase
	end

	// ---------------- sequencer and datapath registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			hint_q       <= '0;
			q_q          <= '0;
			nq_q         <= NQ_W'(1);
			rrn_q        <= '0;
			ne_q         <= '0;
			lpop_q       <= '0;
			steal_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			q_q     <= q_d;
			if (num_queues_wr) begin
				nq_q <= num_queues;
			end
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (in_xfer) begin
						cmd_q        <= cmd_t'(cmd);
						fid_q        <= fiber_id;
						worker_q     <= worker;
						rr_q         <= use_round_robin;
						outcome_q    <= outcome;
						scan_q       <= hint_q;
						steal_mode_q <= 1'b0;
						off_q        <= NQ_W'(1);
						res_task_q   <= '0;
						res_found_q  <= 1'b0;
						res_stolen_q <= 1'b0;
						res_ovf_q    <= 1'b0;
						me_q         <= q_d;
					end
				end
				S_SP_RD: begin
					if (scan_q == SCAN_W'(TASK_SLOTS)) begin
						hint_q <= scan_q;
					end
				end
				S_SP_CHK: begin
					if (sp_hit) begin
						slot_q      <= scan_q[SLOT_W-1:0];
						hint_q      <= scan_q + 1'b1;
						res_task_q  <= TASK_W'(scan_q);
						res_found_q <= 1'b1;
						rrmod_q     <= NQ_W'(rrn_q);
						if (enq_rr) begin
							rrn_q <= rrn_q + 1'b1;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FID_CHK: begin
					slot_q  <= fid_q[SLOT_W-1:0];
					rrmod_q <= NQ_W'(rrn_q);
					if (((cmd_q == CMD_UNPARK && st_rdata == TS_PARKED) ||
							(cmd_q == CMD_COMPLETE && st_rdata == TS_RUNNING &&
							outcome_q == OC_YIELD)) && enq_rr) begin
						rrn_q <= rrn_q + 1'b1;
					end
					if (cmd_q == CMD_COMPLETE && st_rdata == TS_RUNNING &&
							outcome_q == OC_EXIT &&
							SCAN_W'(fid_q[SLOT_W-1:0]) < hint_q) begin
						hint_q <= SCAN_W'(fid_q[SLOT_W-1:0]);
					end
				end
				S_RR_MOD: begin
					// round_robin_next mod queue count by repeated subtraction
					if (rrmod_q >= n_q) begin
						rrmod_q <= rrmod_q - n_q;
					end
				end
				S_PUSH, S_SCAN_PUSH: begin
					if (!q_full) begin
						ne_q[q_q] <= 1'b1;
					end
				end
				S_PARK: begin
					res_ovf_q <= 1'b1;
				end
				S_POP: begin
					if (!q_empty) begin
						ne_q[q_q] <= (t_prv != h_cur);
					end else begin
						steal_mode_q <= 1'b1;
					end
				end
				S_STEAL: begin
					if (!q_empty) begin
						ne_q[q_q] <= (h_nxt != t_cur);
					end else begin
						off_q <= off_q + 1'b1;
					end
				end
				S_ENT: begin
					slot_q <= ent_rdata[SLOT_W-1:0];
				end
				S_STAT: begin
					if (stat_ready) begin
						res_task_q  <= TASK_W'(slot_q);
						res_found_q <= 1'b1;
						if (steal_mode_q) begin
							res_stolen_q <= 1'b1;
							steal_q      <= steal_q + 1'b1;
						end else begin
							lpop_q <= lpop_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (done_load) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result payload, loaded as the request finishes; held while stalled
	always_ff @(posedge clk) begin
		if (done_load) begin
			task_out_q  <= res_task_q;
			found_q     <= res_found_q;
			stolen_q    <= res_stolen_q;
			ovf_q       <= res_ovf_q;
			pend_q      <= |(ne_q & qmask);
			lpop_out_q  <= lpop_q;
			steal_out_q <= steal_q;
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign task_out        = task_out_q;
	assign found           = found_q;
	assign stolen          = stolen_q;
	assign overflow        = ovf_q;
	assign work_pending    = pend_q;
	assign local_pop_count = lpop_out_q;
	assign steal_count     = steal_out_q;

	// ---------------- assertions ----------------
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared without finishing a request");

	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= SCAN_W'(TASK_SLOTS))
		else $error("free-slot hint out of range");

	a_steal_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(stolen_q && (!found_q || ovf_q)))
		else $error("steal flagged without a found task");

	a_ent_write: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> ((state_q == S_PUSH || state_q == S_SCAN_PUSH) && !q_full))
		else $error("deque entry written outside a push");

endmodule
`default_nettype wire

### tb/work_stealing_ready_queues_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// work_stealing_ready_queues_unit_test
// Self-checking bench for the task scheduler. Requests are queued by a
// stimulus process and driven one transfer at a time. Each accepted request
// runs through a behavioural scheduler model, and the result it gives is
// compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module work_stealing_ready_queues_unit_test;
	import wsrq_pkg::*;

	typedef struct {
		cmd_t             op;
		logic [TASK_W-1:0] fid;
		logic [WORKER_W-1:0] wk;
		logic             rr;
		logic [1:0]       oc;
	} sched_req_t;

	typedef struct {
		logic [TASK_W-1:0] slot;
		logic             got;
		logic             stole;
		logic             ovf;
		logic             pend;
		logic [CNT_W-1:0] pops;
		logic [CNT_W-1:0] stl;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic num_queues_wr = 1'b0;
	logic [NQ_W-1:0] num_queues = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [TASK_W-1:0] fiber_id = '0;
	logic [WORKER_W-1:0] worker = '0;
	logic use_round_robin = 1'b0;
	logic [1:0] outcome = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TASK_W-1:0] task_out;
	logic found, stolen, overflow, work_pending;
	logic [CNT_W-1:0] local_pop_count, steal_count;

	work_stealing_ready_queues_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.num_queues_wr(num_queues_wr), .num_queues(num_queues),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .fiber_id(fiber_id), .worker(worker),
		.use_round_robin(use_round_robin), .outcome(outcome),
		.out_valid(out_valid), .out_stall(out_stall),
		.task_out(task_out), .found(found), .stolen(stolen),
		.overflow(overflow), .work_pending(work_pending),
		.local_pop_count(local_pop_count), .steal_count(steal_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scheduler model: status table, ring deques, counters
	// ------------------------------------------------------------------
	logic [STAT_W-1:0] slot_state [TASK_SLOTS];
	logic [TASK_W-1:0] ring [MAX_QUEUES*DEQUE_DEPTH];
	logic [PTR_W-1:0]  ring_head [MAX_QUEUES];
	logic [PTR_W-1:0]  ring_tail [MAX_QUEUES];
	logic [RR_W-1:0]   rr_next;
	logic [CNT_W-1:0]  own_pops, steal_total;
	logic [NQ_W-1:0]   queues_reg;

	sched_req_t pending_reqs[$];
	sched_res_t expected_res[$];
	bit failed = 0;
	bit calm = 0;   // no idling on either side while set

	function automatic int active_queues();
		if (queues_reg == 0) return 1;
		if (queues_reg > MAX_QUEUES) return MAX_QUEUES;
		return queues_reg;
	endfunction

	function automatic bit ring_push(int q, logic [TASK_W-1:0] s);
		logic [PTR_W-1:0] nxt;
		nxt = ring_tail[q] + 1'b1;
		if (nxt == ring_head[q]) return 0;
		ring[q*DEQUE_DEPTH + ring_tail[q]] = s;
		ring_tail[q] = nxt;
		return 1;
	endfunction

	// returns 1 when every deque was full and the slot got parked
	function automatic bit place_task(logic [TASK_W-1:0] s, int wk, bit rr);
		int n, q;
		n = active_queues();
		q = wk;
		if (rr || q >= n) begin
			q = rr_next % n;
			rr_next = rr_next + 1'b1;
		end
		if (ring_push(q, s)) return 0;
		for (int i = 0; i < n; i++)
			if (ring_push(i, s)) return 0;
		slot_state[s] = TS_PARKED;
		return 1;
	endfunction

	// pops until a ready slot appears; stale entries are dropped
	function automatic bit ring_take(int q, bit from_head, output logic [TASK_W-1:0] s);
		logic [TASK_W-1:0] id;
		s = '0;
		while (ring_head[q] != ring_tail[q]) begin
			if (from_head) begin
				id = ring[q*DEQUE_DEPTH + ring_head[q]];
				ring_head[q] = ring_head[q] + 1'b1;
			end else begin
				ring_tail[q] = ring_tail[q] - 1'b1;
				id = ring[q*DEQUE_DEPTH + ring_tail[q]];
			end
			if (slot_state[id] == TS_READY) begin
				slot_state[id] = TS_RUNNING;
				s = id;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic sched_res_t schedule_step(sched_req_t r);
		sched_res_t o;
		int n, me, i;
		logic [TASK_W-1:0] id;
		o = '{default: '0};
		n = active_queues();
		case (r.op)
			CMD_SPAWN: begin
				for (i = 0; i < TASK_SLOTS; i++)
					if (slot_state[i] == TS_FREE || slot_state[i] == TS_DONE) break;
				if (i < TASK_SLOTS) begin
					slot_state[i] = TS_READY;
					o.slot = TASK_W'(i);
					o.got = 1;
					o.ovf = place_task(TASK_W'(i), int'(r.wk), r.rr);
				end
			end
			CMD_UNPARK: begin
				if (slot_state[r.fid] == TS_PARKED) begin
					slot_state[r.fid] = TS_READY;
					o.ovf = place_task(r.fid, int'(r.wk), r.rr);
				end
			end
			CMD_TAKE: begin
				me = (r.rr || r.wk >= n) ? 0 : int'(r.wk);
				if (ring_take(me, 0, id)) begin
					own_pops++;
					o.slot = id;
					o.got = 1;
				end else begin
					for (int off = 1; off < n; off++)
						if (ring_take((me + off) % n, 1, id)) begin
							steal_total++;
							o.slot = id;
							o.got = 1;
							o.stole = 1;
							break;
						end
				end
			end
			default: begin
				if (slot_state[r.fid] == TS_RUNNING) begin
					if (r.oc == OC_YIELD) begin
						slot_state[r.fid] = TS_READY;
						o.ovf = place_task(r.fid, int'(r.wk), r.rr);
					end else if (r.oc == OC_PARK)
						slot_state[r.fid] = TS_PARKED;
					else if (r.oc == OC_EXIT)
						slot_state[r.fid] = TS_DONE;
				end
			end
		endcase
		for (i = 0; i < n; i++)
			if (ring_head[i] != ring_tail[i]) o.pend = 1;
		o.pops = own_pops;
		o.stl = steal_total;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Driver: request channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sched_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				r.op = cmd_t'(cmd);
				r.fid = fiber_id;
				r.wk = worker;
				r.rr = use_round_robin;
				r.oc = outcome;
				expected_res.push_back(schedule_step(r));
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					cmd <= r.op;
					fiber_id <= r.fid;
					worker <= r.wk;
					use_round_robin <= r.rr;
					outcome <= r.oc;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: result channel, checked against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sched_res_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_res.size() == 0) begin
					$display("%0t: result with nothing expected, task_out %0d", $time, task_out);
					failed = 1;
				end else begin
					e = expected_res.pop_front();
					if (task_out !== e.slot || found !== e.got || stolen !== e.stole ||
					    overflow !== e.ovf || work_pending !== e.pend ||
					    local_pop_count !== e.pops || steal_count !== e.stl) begin
						$display("%0t: mismatch expected task %0d found %b stolen %b ovf %b pend %b pops %0d steals %0d",
							$time, e.slot, e.got, e.stole, e.ovf, e.pend, e.pops, e.stl);
						$display("%0t:          actual task %0d found %b stolen %b ovf %b pend %b pops %0d steals %0d",
							$time, task_out, found, stolen, overflow, work_pending,
							local_pop_count, steal_count);
						failed = 1;
					end
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 11);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic add_req(cmd_t op, int fid, int wk, bit rr, int oc);
		sched_req_t r;
		r.op = op;
		r.fid = TASK_W'(fid);
		r.wk = WORKER_W'(wk);
		r.rr = rr;
		r.oc = 2'(oc);
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
			@(posedge clk);
	endtask

	task automatic set_queues(int v);
		wait_drained();
		repeat (30) @(posedge clk);
		num_queues <= NQ_W'(v);
		num_queues_wr <= 1'b1;
		queues_reg = NQ_W'(v);
		@(posedge clk);
		num_queues_wr <= 1'b0;
	endtask

	// mixed traffic; low slot numbers so that completes and unparks
	// mostly hit live tasks, with the odd full-range id
	task automatic add_traffic(int count, int span);
		int p, fid;
		for (int k = 0; k < count; k++) begin
			p = $urandom_range(99);
			fid = ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(span);
			if (p < 28)
				add_req(CMD_SPAWN, fid, $urandom_range(63), $urandom_range(1), $urandom_range(3));
			else if (p < 38)
				add_req(CMD_UNPARK, fid, $urandom_range(63), $urandom_range(1), $urandom_range(3));
			else if (p < 68)
				add_req(CMD_TAKE, fid, $urandom_range(63), $urandom_range(1), $urandom_range(3));
			else
				add_req(CMD_COMPLETE, fid, $urandom_range(63), $urandom_range(1),
					($urandom_range(9) == 0) ? 3 : $urandom_range(2));
		end
	endtask

	initial begin
		for (int i = 0; i < TASK_SLOTS; i++) slot_state[i] = TS_FREE;
		for (int i = 0; i < MAX_QUEUES; i++) begin
			ring_head[i] = '0;
			ring_tail[i] = '0;
		end
		rr_next = '0;
		own_pops = '0;
		steal_total = '0;
		queues_reg = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		set_queues(1);
		// directed: life cycle of a couple of slots on a single deque
		add_req(CMD_TAKE,     0,    0,  0, 0);   // take from empty deques
		add_req(CMD_SPAWN,    0,    0,  0, 0);   // slot 0 on own deque
		add_req(CMD_SPAWN,    0,    63, 0, 0);   // worker beyond count: round robin
		add_req(CMD_TAKE,     0,    0,  0, 0);   // own tail gives slot 1
		add_req(CMD_COMPLETE, 1,    0,  0, OC_YIELD);
		add_req(CMD_COMPLETE, 1,    0,  0, OC_YIELD);   // not running: ignored
		add_req(CMD_TAKE,     0,    5,  1, 0);
		add_req(CMD_COMPLETE, 1,    0,  0, OC_PARK);
		add_req(CMD_UNPARK,   1,    0,  1, 0);
		add_req(CMD_UNPARK,   1,    0,  0, 0);   // not parked: ignored
		add_req(CMD_TAKE,     0,    0,  0, 0);
		add_req(CMD_COMPLETE, 1,    0,  0, 3);   // unknown outcome: stays running
		add_req(CMD_COMPLETE, 1,    0,  0, OC_EXIT);
		add_req(CMD_TAKE,     4095, 63, 1, 3);
		add_req(CMD_COMPLETE, 0,    0,  0, OC_EXIT);
		add_req(CMD_SPAWN,    4095, 0,  0, 3);   // reuses a done slot
		add_req(CMD_UNPARK,   4095, 63, 1, 3);
		add_req(CMD_COMPLETE, 4095, 63, 1, OC_PARK);
		add_req(CMD_TAKE,     0,    0,  0, 0);
		add_req(CMD_TAKE,     0,    0,  0, 0);

		// all deques in use, first stretch without any idling
		set_queues(64);
		calm = 1;
		add_traffic(120, 60);
		wait_drained();
		calm = 0;
		add_traffic(200, 80);
		wait_drained();          // sender held until every result is back
		add_traffic(100, 80);

		// zero counts as one deque; fill it to force overflow, then drain
		set_queues(0);
		for (int k = 0; k < 520; k++)
			add_req(CMD_SPAWN, $urandom_range(4095), $urandom_range(63),
				$urandom_range(1), $urandom_range(3));
		for (int k = 0; k < 40; k++)
			add_req(CMD_TAKE, 0, $urandom_range(63), $urandom_range(1), 0);
		add_traffic(60, 700);

		set_queues(127);         // clamps to the maximum
		add_traffic(120, 120);

		set_queues(5);
		add_traffic(150, 120);

		wait_drained();
		repeat (40) @(posedge clk);
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
